/* rtl/sha2_pkg.sv */
// Shared types, round constants and initial hash values for the SHA-2 hash block.
package sha2_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOAD,
    ST_ROUND,
    ST_CFIN,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_SPLIT,
    PH_FINAL
  } phase_t;

  localparam logic [2:0] MODE_SHA224     = 3'd0;
  localparam logic [2:0] MODE_SHA256     = 3'd1;
  localparam logic [2:0] MODE_SHA384     = 3'd2;
  localparam logic [2:0] MODE_SHA512     = 3'd3;
  localparam logic [2:0] MODE_SHA512_224 = 3'd4;
  localparam logic [2:0] MODE_SHA512_256 = 3'd5;

  // The 32-bit round constants are the upper halves of the first 64 of these.
  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0: k = 64'h428A2F98D728AE22;  7'd1: k = 64'h7137449123EF65CD;
      7'd2: k = 64'hB5C0FBCFEC4D3B2F;  7'd3: k = 64'hE9B5DBA58189DBBC;
      7'd4: k = 64'h3956C25BF348B538;  7'd5: k = 64'h59F111F1B605D019;
      7'd6: k = 64'h923F82A4AF194F9B;  7'd7: k = 64'hAB1C5ED5DA6D8118;
      7'd8: k = 64'hD807AA98A3030242;  7'd9: k = 64'h12835B0145706FBE;
      7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
      7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
      7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
      7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
      7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
      7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
      7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
      7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
      7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
      7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
      7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
      7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
      7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
      7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
      7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
      7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
      7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
      7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
      7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
      7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
      7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
      7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
      7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
      7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
      7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
      7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
      7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
      7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
      7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
      7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
      7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
      7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
      7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
      7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
      7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] iv_384(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'hcbbb9d5dc1059ed8; 3'd1: v = 64'h629a292a367cd507;
      3'd2: v = 64'h9159015a3070dd17; 3'd3: v = 64'h152fecd8f70e5939;
      3'd4: v = 64'h67332667ffc00b31; 3'd5: v = 64'h8eb44a8768581511;
      3'd6: v = 64'hdb0c2e0d64f98fa7; default: v = 64'h47b5481dbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] iv_512(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'h6a09e667f3bcc908; 3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b; 3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1; 3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b; default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] iv_512_224(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'h8C3D37C819544DA2; 3'd1: v = 64'h73E1996689DCD4D6;
      3'd2: v = 64'h1DFAB7AE32FF9C82; 3'd3: v = 64'h679DD514582F9FCF;
      3'd4: v = 64'h0F6D2B697BD44DA8; 3'd5: v = 64'h77E36F7304C48942;
      3'd6: v = 64'h3F9D85A86A1D36C8; default: v = 64'h1112E6AD91D692A1;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] iv_512_256(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'h22312194fc2bf72c; 3'd1: v = 64'h9f555fa3c84c64c2;
      3'd2: v = 64'h2393b86b6f53b151; 3'd3: v = 64'h963877195940eabd;
      3'd4: v = 64'h96283ee2a88effe3; 3'd5: v = 64'hbe5e1e2553863992;
      3'd6: v = 64'h2b0199fc2c85b8aa; default: v = 64'h0eb72ddc81c52ca2;
    endcase
    return v;
  endfunction

  // SHA-224 uses the low halves of the SHA-384 values, SHA-256 the high halves of SHA-512.
  function automatic logic [63:0] init_hash(input logic [2:0] mode, input logic [2:0] idx);
    logic [63:0] v;
    logic [63:0] full;
    case (mode)
      MODE_SHA224: begin
        full = iv_384(idx);
        v = {32'h0, full[31:0]};
      end
      MODE_SHA384:     v = iv_384(idx);
      MODE_SHA512:     v = iv_512(idx);
      MODE_SHA512_224: v = iv_512_224(idx);
      MODE_SHA512_256: v = iv_512_256(idx);
      default: begin
        full = iv_512(idx);
        v = {32'h0, full[63:32]};
      end
    endcase
    return v;
  endfunction

  function automatic logic [6:0] digest_bytes(input logic [2:0] mode);
    logic [6:0] b;
    case (mode)
      MODE_SHA224:     b = 7'd28;
      MODE_SHA384:     b = 7'd48;
      MODE_SHA512:     b = 7'd64;
      MODE_SHA512_224: b = 7'd28;
      default:         b = 7'd32;
    endcase
    return b;
  endfunction

endpackage

/* rtl/sha2_family_hash.sv */
// SHA-2 family hash engine with the message block and schedule fed from one buffer memory.
//
//  channel   dir  beat contents (tdata / tuser / tlast)
//  s_*       in   data_word / byte_count / last_item
//  m_*       out  digest_word / valid_bytes / last_word
//  cfg_*     in   hash_mode write, no handshake
//
// A full block is compressed by a memory read setup, one round per cycle and a final fold of
// the result into the hash. The last beat adds the padding writes, one or two compressions
// and one result beat per cycle while m_tready is high.
// Reset is synchronous and loads the SHA-256 initial values; a mode write restarts the message.
// The input stalls from a full block until its compression ends and during finishing.
module sha2_family_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // data_word
  input  logic [3:0]  s_tuser,   // byte_count
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // digest_word
  output logic [3:0]  m_tuser,   // valid_bytes
  output logic        m_tlast,   // last_word
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata  // hash_mode
);
  import sha2_pkg::*;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PAD_MARK = 64'h8000_0000_0000_0000;

  state_t      state, state_next;
  phase_t      phase;
  logic [2:0]  mode;
  logic [63:0] hash [8];
  logic [63:0] v [8];
  logic [63:0] w [16];
  logic [7:0]  fill;
  logic [63:0] len0, len1;
  logic [6:0]  t;
  logic [3:0]  pidx;
  logic [2:0]  k;
  logic        last_pend;
  logic [63:0] pad_word;

  logic [63:0] mem [16];
  logic [63:0] rdata;
  logic        mem_we;
  logic [3:0]  mem_waddr, mem_raddr;
  logic [63:0] mem_wdata;

  logic [2:0]  cmode;
  logic        wide;
  logic [7:0]  bsize;
  logic [3:0]  wlast;
  logic [6:0]  rounds;
  logic        accept;
  logic [3:0]  n_eff;
  logic [63:0] d_mask;
  logic [7:0]  fill_sum;
  logic        full;
  logic        two_block;
  logic [6:0]  dbytes;
  logic [2:0]  nres_m1;
  logic [6:0]  rem;
  logic [63:0] out_word;
  logic [6:0]  t_inc;

  logic [63:0] w_mem, w_sched, w_cur, kw, kc;
  logic [63:0] s0_sched, s1_sched, big0, big1, ch, maj, t1, t2, e_new, a_new, wmask;

  assign cmode  = (mode > MODE_SHA512_256) ? MODE_SHA256 : mode;
  assign wide   = (cmode >= MODE_SHA384);
  assign bsize  = wide ? 8'd128 : 8'd64;
  assign wlast  = wide ? 4'd15 : 4'd7;
  assign rounds = wide ? 7'd80 : 7'd64;
  assign wmask  = wide ? ONES : 64'h0000_0000_FFFF_FFFF;
  assign accept = s_tvalid && s_tready;
  assign n_eff  = (!s_tlast || s_tuser > 4'd8) ? 4'd8 : s_tuser;
  assign d_mask = (n_eff == 4'd8) ? s_tdata : (s_tdata & ~(ONES >> {n_eff, 3'b000}));
  assign fill_sum  = fill + {4'd0, n_eff};
  assign full      = (n_eff != 4'd0) && (fill_sum >= bsize);
  assign two_block = fill >= (bsize - (wide ? 8'd16 : 8'd8));
  assign dbytes    = digest_bytes(cmode);
  assign nres_m1   = 3'(dbytes[6:3] + {3'd0, dbytes[2:0] != 3'd0} - 4'd1);
  assign rem       = dbytes - {1'b0, k, 3'b000};
  assign t_inc     = t + 7'd1;

  // Round datapath; 32-bit modes run on the low half of each word.
  assign w_mem    = wide ? rdata : {32'h0, t[0] ? rdata[31:0] : rdata[63:32]};
  assign s0_sched = wide ?
      ({w[1][0], w[1][63:1]} ^ {w[1][7:0], w[1][63:8]} ^ (w[1] >> 7)) :
      {32'h0, {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1][31:0] >> 3)};
  assign s1_sched = wide ?
      ({w[14][18:0], w[14][63:19]} ^ {w[14][60:0], w[14][63:61]} ^ (w[14] >> 6)) :
      {32'h0, {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]}
              ^ (w[14][31:0] >> 10)};
  assign w_sched = (s1_sched + w[9] + s0_sched + w[0]) & wmask;
  assign w_cur   = (t < 7'd16) ? w_mem : w_sched;
  assign kc      = round_k(t);
  assign kw      = (wide ? kc : {32'h0, kc[63:32]}) + w_cur;
  assign big1 = wide ?
      ({v[4][13:0], v[4][63:14]} ^ {v[4][17:0], v[4][63:18]} ^ {v[4][40:0], v[4][63:41]}) :
      {32'h0, {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
              ^ {v[4][24:0], v[4][31:25]}};
  assign big0 = wide ?
      ({v[0][27:0], v[0][63:28]} ^ {v[0][33:0], v[0][63:34]} ^ {v[0][38:0], v[0][63:39]}) :
      {32'h0, {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
              ^ {v[0][21:0], v[0][31:22]}};
  assign ch    = ((v[4] & v[5]) ^ (~v[4] & v[6])) & wmask;
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + big1 + ch + kw;
  assign t2    = big0 + maj;
  assign e_new = (v[3] + t1) & wmask;
  assign a_new = (t1 + t2) & wmask;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (full) state_next = ST_CLOAD;
          else if (s_tlast) state_next = ST_PAD;
        end
      end
      ST_CLOAD: state_next = ST_ROUND;
      ST_ROUND: if (t_inc == rounds) state_next = ST_CFIN;
      ST_CFIN: begin
        case (phase)
          PH_DATA:  state_next = last_pend ? ST_PAD : ST_IDLE;
          PH_SPLIT: state_next = ST_ZERO;
          default:  state_next = ST_OUT;
        endcase
      end
      ST_PAD:  if (pidx == wlast) state_next = two_block ? ST_CLOAD : ST_LEN;
      ST_ZERO: if (pidx == wlast) state_next = ST_LEN;
      ST_LEN:  if (pidx == wlast) state_next = ST_CLOAD;
      ST_OUT:  if (m_tready && k == nres_m1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    m_tvalid  = (state == ST_OUT);
    mem_we    = 1'b0;
    mem_waddr = pidx;
    mem_wdata = 64'h0;
    mem_raddr = wide ? t_inc[3:0] : t_inc[4:1];
    case (state)
      ST_IDLE: begin
        mem_we    = accept && (n_eff != 4'd0);
        mem_waddr = fill[6:3];
        mem_wdata = d_mask;
      end
      ST_CLOAD: mem_raddr = 4'd0;
      ST_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = (pidx == fill[6:3]) ? pad_word : 64'h0;
      end
      ST_ZERO: mem_we = 1'b1;
      ST_LEN: begin
        mem_we    = 1'b1;
        mem_wdata = (wide && pidx == 4'd14) ? len1 : len0;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (wide) out_word = hash[k];
    else out_word = {hash[{k[1:0], 1'b0}][31:0], hash[{k[1:0], 1'b1}][31:0]};
    if (rem < 7'd8) begin
      m_tdata = out_word & ~(ONES >> {rem[3:0], 3'b000});
      m_tuser = rem[3:0];
    end else begin
      m_tdata = out_word;
      m_tuser = 4'd8;
    end
    m_tlast = (k == nres_m1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_DATA;
      mode  <= MODE_SHA256;
      fill  <= 8'd0;
      len0  <= 64'd0;
      len1  <= 64'd0;
      t     <= 7'd0;
      pidx  <= 4'd0;
      k     <= 3'd0;
      last_pend <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= init_hash(MODE_SHA256, 3'(i));
        v[i]    <= 64'd0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase     <= PH_DATA;
            last_pend <= s_tlast;
            pad_word  <= (n_eff == 4'd8) ? PAD_MARK : (d_mask | (PAD_MARK >> {n_eff, 3'b000}));
            pidx      <= full ? 4'd0 : fill_sum[6:3];
            if (n_eff != 4'd0) begin
              fill <= full ? 8'd0 : fill_sum;
              len0 <= len0 + {57'd0, n_eff, 3'b000};
              if (wide && (len0 + {57'd0, n_eff, 3'b000}) < {57'd0, n_eff, 3'b000})
                len1 <= len1 + 64'd1;
            end
          end
        end
        ST_CLOAD: begin
          t <= 7'd0;
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
        end
        ST_ROUND: begin
          t <= t_inc;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_cur;
          v[0] <= a_new;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= e_new;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
        end
        ST_CFIN: begin
          t <= 7'd0;
          for (int i = 0; i < 8; i++) hash[i] <= (hash[i] + v[i]) & wmask;
          pidx <= (phase == PH_SPLIT) ? 4'd0 : fill[6:3];
          k    <= 3'd0;
        end
        ST_PAD: begin
          if (pidx == wlast) begin
            phase <= two_block ? PH_SPLIT : PH_FINAL;
            pidx  <= two_block ? pidx : (wide ? 4'd14 : 4'd7);
          end else begin
            pidx <= pidx + 4'd1;
          end
        end
        ST_ZERO: pidx <= (pidx == wlast) ? (wide ? 4'd14 : 4'd7) : pidx + 4'd1;
        ST_LEN: begin
          if (pidx == wlast) phase <= PH_FINAL;
          else pidx <= pidx + 4'd1;
        end
        ST_OUT: begin
          if (m_tready) begin
            k <= k + 3'd1;
            if (k == nres_m1) begin
              fill <= 8'd0;
              len0 <= 64'd0;
              len1 <= 64'd0;
              for (int i = 0; i < 8; i++) hash[i] <= init_hash(cmode, 3'(i));
            end
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        mode <= cfg_wdata;
        fill <= 8'd0;
        len0 <= 64'd0;
        len1 <= 64'd0;
        for (int i = 0; i < 8; i++)
          hash[i] <= init_hash((cfg_wdata > MODE_SHA512_256) ? MODE_SHA256 : cfg_wdata, 3'(i));
      end
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input and output open together");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
      state == ST_ROUND |-> t < rounds)
    else $error("round index beyond round count");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
      state == ST_IDLE |-> fill < bsize)
    else $error("block fill at or beyond block size while idle");
  a_restart: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tready && m_tlast |=> state == ST_IDLE && fill == 8'd0 && len0 == 64'd0)
    else $error("message not restarted after final digest beat");
  a_pad_then_len: assert property (@(posedge clk) disable iff (rst)
      state == ST_LEN && pidx == wlast |=> state == ST_CLOAD)
    else $error("length write not followed by compression");

endmodule
